// ----- rtl/ieoc_pkg.sv -----
`default_nettype none
package ieoc_pkg;

	// protocol numbers
	localparam logic [7:0] T_HOP    = 8'd0;
	localparam logic [7:0] T_TCP    = 8'd6;
	localparam logic [7:0] T_UDP    = 8'd17;
	localparam logic [7:0] T_ROUTER = 8'd43;
	localparam logic [7:0] T_FRAG   = 8'd44;
	localparam logic [7:0] T_ESP    = 8'd50;
	localparam logic [7:0] T_AUTH   = 8'd51;
	localparam logic [7:0] T_ICMP6  = 8'd58;
	localparam logic [7:0] T_NONE   = 8'd59;
	localparam logic [7:0] T_DEST   = 8'd60;
	localparam logic [7:0] T_MOB    = 8'd135;
	localparam logic [7:0] T_HIP    = 8'd139;
	localparam logic [7:0] T_SHIM6  = 8'd140;
	localparam logic [7:0] T_EXP1   = 8'd253;
	localparam logic [7:0] T_EXP2   = 8'd254;

	// flag bits; bit 9 is the internal dest-before-router mark
	localparam logic [9:0] F_NONEXT = 10'h001;
	localparam logic [9:0] F_ESP    = 10'h002;
	localparam logic [9:0] F_AUTH   = 10'h004;
	localparam logic [9:0] F_DEST   = 10'h008;
	localparam logic [9:0] F_FRAG   = 10'h010;
	localparam logic [9:0] F_ROUTER = 10'h020;
	localparam logic [9:0] F_HOP    = 10'h040;
	localparam logic [9:0] F_UNREP  = 10'h080;
	localparam logic [9:0] F_UNSEQ  = 10'h100;
	localparam logic [9:0] F_DESTRT = 10'h200;

	// allowed predecessors per header kind
	localparam logic [9:0] PRE_HOP    = 10'h000;
	localparam logic [9:0] PRE_DESTRT = PRE_HOP | F_HOP;
	localparam logic [9:0] PRE_ROUTER = PRE_DESTRT | F_DESTRT;
	localparam logic [9:0] PRE_FRAG   = PRE_ROUTER | F_ROUTER;
	localparam logic [9:0] PRE_AUTH   = PRE_FRAG | F_FRAG;
	localparam logic [9:0] PRE_ESP    = PRE_AUTH | F_AUTH;
	localparam logic [9:0] PRE_DEST   = PRE_ESP | F_ESP;

	localparam logic [15:0] HDR_UNIT = 16'd8;

	typedef struct packed {
		logic        start_req;
		logic [7:0]  curr_hdr;
		logic [7:0]  ext_next_hdr;
		logic [7:0]  ext_len_byte;
		logic [15:0] remaining_len;
	} hdr_t;

	typedef struct packed {
		logic [7:0]  next_type;
		logic [11:0] consumed_len;
		logic [7:0]  upper_proto;
		logic [8:0]  exthdr_flags;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/ieoc_step.sv -----
`default_nettype none
module ieoc_step (
	input  var ieoc_pkg::hdr_t hdr,
	input  wire logic [9:0]    seen,
	output var ieoc_pkg::res_t res,
	output logic [9:0]         seen_nxt
);
	import ieoc_pkg::*;

	function automatic logic is_ignored(input logic [7:0] t);
		return t == T_MOB || t == T_HIP || t == T_SHIM6 || t == T_EXP1 || t == T_EXP2;
	endfunction

	function automatic logic is_ext(input logic [7:0] t);
		return t == T_HOP || t == T_ROUTER || t == T_FRAG || t == T_ESP ||
			t == T_AUTH || t == T_DEST || is_ignored(t);
	endfunction

	function automatic logic [9:0] mark(input logic [9:0] s, input logic [9:0] b,
		input logic [9:0] pre);
		logic [9:0] r;
		r = s;
		if ((s & ~(b | pre)) != 10'd0)
			r = r | F_UNSEQ;
		if ((s & b) != 10'd0)
			r = r | F_UNREP;
		return r | b;
	endfunction

	logic [9:0]  s0;
	logic [9:0]  s1;
	logic [11:0] hlen;
	logic        known;
	logic        walk;

	assign s0 = hdr.start_req ? 10'd0 : seen;
	assign hlen = (hdr.curr_hdr == T_FRAG) ? HDR_UNIT[11:0]
		: ({1'b0, hdr.ext_len_byte, 3'b000} + HDR_UNIT[11:0]);

	always_comb begin
		s1    = s0;
		known = 1'b1;
		walk  = 1'b0;
		res.next_type    = T_NONE;
		res.consumed_len = 12'd0;
		res.upper_proto  = 8'd0;
		if (hdr.curr_hdr == T_NONE) begin
			walk = 1'b0;
		end else if (hdr.curr_hdr == T_TCP || hdr.curr_hdr == T_UDP ||
			hdr.curr_hdr == T_ICMP6) begin
			res.upper_proto = hdr.curr_hdr;
		end else if (hdr.remaining_len < HDR_UNIT) begin
			walk = 1'b0;
		end else begin
			walk = 1'b1;
			case (hdr.curr_hdr)
				T_HOP: begin
					s1 = mark(s0, F_HOP, PRE_HOP);
				end
				T_DEST: begin
					if (hdr.ext_next_hdr == T_ROUTER)
						s1 = mark(s0, F_DESTRT, PRE_DESTRT);
					else if (!is_ext(hdr.ext_next_hdr))
						s1 = mark(s0, F_DEST, PRE_DEST);
					else
						s1 = s0 | F_DEST | F_UNSEQ | (((s0 & F_DEST) != 10'd0) ? F_UNREP : 10'd0);
				end
				T_ROUTER: s1 = mark(s0, F_ROUTER, PRE_ROUTER);
				T_FRAG:   s1 = mark(s0, F_FRAG, PRE_FRAG);
				T_AUTH:   s1 = mark(s0, F_AUTH, PRE_AUTH);
				T_ESP:    s1 = mark(s0, F_ESP, PRE_ESP);
				default:  known = is_ignored(hdr.curr_hdr);
			endcase
			if (walk && known && ({4'b0, hlen} <= hdr.remaining_len)) begin
				res.consumed_len = hlen;
				res.next_type    = hdr.ext_next_hdr;
			end
		end
		seen_nxt = s1;
		if (s1 == 10'd0)
			res.exthdr_flags = F_NONEXT[8:0];
		else if (s1[9])
			res.exthdr_flags = s1[8:0] | F_DEST[8:0];
		else
			res.exthdr_flags = s1[8:0];
		res.last = (res.next_type == T_NONE);
	end

endmodule
`default_nettype wire

// ----- rtl/ipv6_ext_header_order_checker_top.sv -----
`default_nettype none
// IPv6 extension-header chain walker.
// Feed one header per request on the hdr channel (valid/ready); set
// start_req on the first header after the base header to clear the
// accumulated flags. Each request gives exactly one result on the res
// channel: next header type (59 when the walk ends), bytes consumed,
// upper-layer protocol and the OpenFlow ext-header flag summary.
// Throughput: one request per cycle unless res_ready stalls the output;
// the flag update for each header is a single combinational pass between
// the input stage and the result register, with the flag register
// written as the request moves on. When res_ready is low the result
// register holds and the input stage still takes one more request;
// hdr_ready drops only when both are full. Reset clears both stage
// valids and the flags; no result is pending.
module ipv6_ext_header_order_checker_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          hdr_valid,
	output logic               hdr_ready,
	input  var ieoc_pkg::hdr_t hdr,
	output logic               res_valid,
	input  wire logic          res_ready,
	output var ieoc_pkg::res_t res
);
	import ieoc_pkg::*;

	logic       valid_s1;
	hdr_t       hdr_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic [9:0] seen_q;
	res_t       step_res;
	logic [9:0] seen_nxt;
	logic       adv;

	ieoc_step u_step (
		.hdr      (hdr_s1),
		.seen     (seen_q),
		.res      (step_res),
		.seen_nxt (seen_nxt)
	);

	assign adv       = valid_s1 && (!valid_s2 || res_ready);
	assign hdr_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			seen_q   <= 10'd0;
		end else begin
			if (hdr_ready)
				valid_s1 <= hdr_valid;
			if (adv) begin
				valid_s2 <= 1'b1;
				seen_q   <= seen_nxt;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_ready && hdr_valid)
			hdr_s1 <= hdr;
		if (adv)
			res_s2 <= step_res;
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule
`default_nettype wire

// ----- rtl/ieoc_checker.sv -----
`default_nettype none
module ieoc_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input var ieoc_pkg::res_t res
);
	import ieoc_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.last == (res.next_type == T_NONE))
		else $error("last does not match next_type");

	// consumed length is whole 8-byte units, at most 256 of them, never for an upper layer
	a_cons: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.consumed_len != 12'd0 |->
		res.consumed_len[2:0] == 3'd0 && res.consumed_len <= 12'd2048 &&
		res.upper_proto == 8'd0)
		else $error("bad consumed length");

	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.upper_proto != 8'd0 |->
		res.last && res.consumed_len == 12'd0 && res.exthdr_flags != 9'd0)
		else $error("upper layer did not end walk");

endmodule

bind ipv6_ext_header_order_checker_top ieoc_checker u_ieoc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
`default_nettype wire
